@@ hw/rtl/scrc_pkg.sv @@
// ---------------------------------------------------------------------------
// scrc_pkg: servo CAN codec shared definitions
// Request/response payload types, opcodes, status codes and the command
// opcode table.
// ---------------------------------------------------------------------------
package scrc_pkg;

   // Identifier bases
   localparam logic [10:0] CMD_ID_BASE = 11'h140;
   localparam logic [10:0] RPL_ID_BASE = 11'h240;

   // Configuration port
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned CSR_DATA_W   = 32;
   localparam logic        REG_MOTOR_ID = 1'b0;
   localparam logic [7:0]  MOTOR_ID_RST = 8'd1;

   // Request kinds
   localparam logic KIND_COMMAND = 1'b0;
   localparam logic KIND_REPLY   = 1'b1;

   // Command selector codes
   localparam logic [3:0] CMD_TORQUE   = 4'd0;
   localparam logic [3:0] CMD_STOP     = 4'd1;
   localparam logic [3:0] CMD_STATUS2  = 4'd2;
   localparam logic [3:0] CMD_STATUS1  = 4'd3;
   localparam logic [3:0] CMD_MT_ANGLE = 4'd4;
   localparam logic [3:0] CMD_ENC_RAW  = 4'd5;
   localparam logic [3:0] CMD_MODE     = 4'd6;
   localparam logic [3:0] CMD_RUNTIME  = 4'd7;
   localparam logic [3:0] CMD_VERSION  = 4'd8;
   localparam logic [3:0] CMD_MODEL    = 4'd9;
   localparam logic [3:0] CMD_POSITION = 4'd10;

   // Frame opcodes (byte 0)
   localparam logic [7:0] OP_NONE     = 8'h00;
   localparam logic [7:0] OP_TORQUE   = 8'hA1;
   localparam logic [7:0] OP_STOP     = 8'h81;
   localparam logic [7:0] OP_STATUS2  = 8'h9C;
   localparam logic [7:0] OP_STATUS1  = 8'h9A;
   localparam logic [7:0] OP_MT_ANGLE = 8'h92;
   localparam logic [7:0] OP_ENC_RAW  = 8'h61;
   localparam logic [7:0] OP_MODE     = 8'h70;
   localparam logic [7:0] OP_RUNTIME  = 8'hB1;
   localparam logic [7:0] OP_VERSION  = 8'hB2;
   localparam logic [7:0] OP_MODEL    = 8'hB5;
   localparam logic [7:0] OP_POSITION = 8'hA5;

   localparam logic [3:0] REPLY_LENGTH = 4'd8;

   // Response status codes
   localparam logic [1:0] ST_BUILT     = 2'd0;
   localparam logic [1:0] ST_ACCEPTED  = 2'd1;
   localparam logic [1:0] ST_BAD_INDEX = 2'd2;
   localparam logic [1:0] ST_BAD_LEN   = 2'd3;

   typedef struct packed {
      logic        kind;
      logic [3:0]  command;
      logic signed [15:0] torque_setpoint;
      logic [15:0] speed_limit;
      logic signed [31:0] target_angle;
      logic [10:0] rx_id;
      logic [3:0]  rx_length;
      logic [63:0] rx_payload;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [10:0] tx_id;
      logic [63:0] tx_payload;
      logic [7:0]  temperature;
      logic [15:0] phase_current;
      logic [15:0] speed_feedback;
      logic [15:0] shaft_angle;
      logic [15:0] supply_voltage;
      logic [15:0] error_flags;
      logic [7:0]  relay_result;
      logic [7:0]  operating_mode;
      logic [63:0] long_value;
   } rsp_payload_type;

   // Telemetry view after one request, handed from decoder to top level
   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  temperature;
      logic [15:0] phase_current;
      logic [15:0] speed_feedback;
      logic [15:0] shaft_angle;
      logic [15:0] supply_voltage;
      logic [15:0] error_flags;
      logic [7:0]  relay_result;
      logic [7:0]  operating_mode;
      logic [63:0] long_value;
   } telem_view_type;

   // Built frame, handed from encoder to top level
   typedef struct packed {
      logic [10:0] tx_id;
      logic [63:0] tx_payload;
   } frame_type;

   function automatic logic [7:0] opcode_of(input logic [3:0] cmd);
      logic [7:0] op;
      case (cmd)
         CMD_TORQUE:   op = OP_TORQUE;
         CMD_STOP:     op = OP_STOP;
         CMD_STATUS2:  op = OP_STATUS2;
         CMD_STATUS1:  op = OP_STATUS1;
         CMD_MT_ANGLE: op = OP_MT_ANGLE;
         CMD_ENC_RAW:  op = OP_ENC_RAW;
         CMD_MODE:     op = OP_MODE;
         CMD_RUNTIME:  op = OP_RUNTIME;
         CMD_VERSION:  op = OP_VERSION;
         CMD_MODEL:    op = OP_MODEL;
         CMD_POSITION: op = OP_POSITION;
         default:      op = OP_NONE;
      endcase
      return op;
   endfunction

endpackage

@@ hw/rtl/scrc_stream_if.sv @@
// ---------------------------------------------------------------------------
// scrc_stream_if: valid/ready channel
// Carries one payload of the given type per handshake.
// ---------------------------------------------------------------------------
interface scrc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/scrc_csr.sv @@
// ---------------------------------------------------------------------------
// scrc_csr: configuration registers
// APB-style write/read of the motor id register.
// ---------------------------------------------------------------------------
module scrc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [scrc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [scrc_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [scrc_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output logic [7:0]                         motor_id
);
   import scrc_pkg::*;

   logic [7:0] motor_id_ff;
   logic [7:0] motor_id_in;
   logic       wr_motor_id;

   assign pready      = 1'b1;
   assign wr_motor_id = psel && penable && pwrite && (paddr[2] == REG_MOTOR_ID);
   assign motor_id_in = wr_motor_id ? pwdata[7:0] : motor_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         motor_id_ff <= MOTOR_ID_RST;
      end else begin
         motor_id_ff <= motor_id_in;
      end
   end

   // Addresses with paddr[2] set read as zero; addresses 0 to 3 all read motor_id
   assign prdata   = (paddr[2] == REG_MOTOR_ID) ? {24'd0, motor_id_ff} : '0;
   assign motor_id = motor_id_ff;

endmodule

@@ hw/rtl/scrc_frame_enc.sv @@
// ---------------------------------------------------------------------------
// scrc_frame_enc: command frame builder
// Forms identifier and 8-byte payload for a command request.
// ---------------------------------------------------------------------------
module scrc_frame_enc (
   input  scrc_pkg::req_payload_type item,
   input  logic [7:0]                motor_id,
   output scrc_pkg::frame_type       frame
);
   import scrc_pkg::*;

   logic [63:0] pay;

   always_comb begin
      pay = {56'd0, opcode_of(item.command)};
      case (item.command)
         CMD_TORQUE: begin
            pay[47:32] = item.torque_setpoint;
         end
         CMD_POSITION: begin
            pay[31:16] = item.speed_limit;
            pay[63:32] = item.target_angle;
         end
         default: begin
         end
      endcase
   end

   // Replies carry no frame
   assign frame.tx_id      = (item.kind == KIND_COMMAND) ?
                             (CMD_ID_BASE + {3'd0, motor_id}) : '0;
   assign frame.tx_payload = (item.kind == KIND_COMMAND) ? pay : '0;

endmodule

@@ hw/rtl/scrc_telemetry.sv @@
// ---------------------------------------------------------------------------
// scrc_telemetry: reply decoder and telemetry store
// Checks reply index and length, updates stored telemetry and presents the
// values as they stand after the request.
// ---------------------------------------------------------------------------
module scrc_telemetry #(
   parameter int unsigned MOTOR_INDEX_LIMIT = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      commit,
   input  scrc_pkg::req_payload_type item,
   output scrc_pkg::telem_view_type  view
);
   import scrc_pkg::*;

   logic [7:0]  temp_ff,    temp_in;
   logic [15:0] current_ff, current_in;
   logic [15:0] speed_ff,   speed_in;
   logic [15:0] angle_ff,   angle_in;
   logic [7:0]  relay_ff,   relay_in;
   logic [15:0] voltage_ff, voltage_in;
   logic [15:0] error_ff,   error_in;
   logic [7:0]  mode_ff,    mode_in;
   logic [63:0] long_value;
   logic [1:0]  status;
   logic [10:0] id_diff;
   logic [7:0]  motor_index;
   logic        index_ok;
   logic [63:0] p;

   assign p           = item.rx_payload;
   assign id_diff     = item.rx_id - RPL_ID_BASE;
   assign motor_index = id_diff[7:0];
   assign index_ok    = {1'b0, motor_index} < 9'(MOTOR_INDEX_LIMIT);

   always_comb begin
      temp_in    = temp_ff;
      current_in = current_ff;
      speed_in   = speed_ff;
      angle_in   = angle_ff;
      relay_in   = relay_ff;
      voltage_in = voltage_ff;
      error_in   = error_ff;
      mode_in    = mode_ff;
      long_value = '0;
      status     = ST_BUILT;
      if (item.kind == KIND_REPLY) begin
         if (!index_ok) begin
            status = ST_BAD_INDEX;
         end else if (item.rx_length != REPLY_LENGTH) begin
            status = ST_BAD_LEN;
         end else begin
            status = ST_ACCEPTED;
            case (p[7:0]) inside
               OP_TORQUE, OP_POSITION, OP_STATUS2: begin
                  temp_in    = p[15:8];
                  current_in = p[31:16];
                  speed_in   = p[47:32];
                  angle_in   = p[63:48];
               end
               OP_STATUS1: begin
                  temp_in    = p[15:8];
                  relay_in   = p[31:24];
                  voltage_in = p[47:32];
                  error_in   = p[63:48];
               end
               OP_RUNTIME, OP_VERSION, OP_ENC_RAW, OP_MT_ANGLE: begin
                  long_value = {32'd0, p[63:32]};
               end
               OP_MODEL: begin
                  long_value = {8'd0, p[63:8]};
               end
               OP_MODE: begin
                  mode_in = p[63:56];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff    <= '0;
         current_ff <= '0;
         speed_ff   <= '0;
         angle_ff   <= '0;
         relay_ff   <= '0;
         voltage_ff <= '0;
         error_ff   <= '0;
         mode_ff    <= '0;
      end else if (commit) begin
         temp_ff    <= temp_in;
         current_ff <= current_in;
         speed_ff   <= speed_in;
         angle_ff   <= angle_in;
         relay_ff   <= relay_in;
         voltage_ff <= voltage_in;
         error_ff   <= error_in;
         mode_ff    <= mode_in;
      end
   end

   assign view.status         = status;
   assign view.temperature    = temp_in;
   assign view.phase_current  = current_in;
   assign view.speed_feedback = speed_in;
   assign view.shaft_angle    = angle_in;
   assign view.supply_voltage = voltage_in;
   assign view.error_flags    = error_in;
   assign view.relay_result   = relay_in;
   assign view.operating_mode = mode_in;
   assign view.long_value     = long_value;

endmodule

@@ hw/rtl/servo_can_command_reply_codec_top.sv @@
// ---------------------------------------------------------------------------
// servo_can_command_reply_codec_top: servo CAN command/reply codec
// Builds command frames and decodes reply frames into stored telemetry.
//
//   channel    | direction | handshake          | carries
//   -----------+-----------+--------------------+------------------------------
//   req_chan   | in        | valid/ready        | command or reply request
//   rsp_chan   | out       | valid/ready        | frame, status, telemetry
//   csr_*      | in/out    | APB psel/penable   | motor_id at addresses 0 to 3
//
// A request is held in the input register and then loads the response
// register, which drives rsp_chan; while rsp_chan stalls, the request
// waits in the input register. One request per cycle is sustained while
// rsp_chan is not stalled.
// Reset clears both valid flags, resets motor_id to 1 and clears telemetry.
// A stalled response holds its register; the input register keeps taking a
// request whenever it is empty or moves forward in the same cycle.
// ---------------------------------------------------------------------------
module servo_can_command_reply_codec_top #(
   parameter int unsigned MOTOR_INDEX_LIMIT = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   scrc_stream_if.sink                        req_chan,
   scrc_stream_if.source                      rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [scrc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [scrc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [scrc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import scrc_pkg::*;

   logic            in_valid_ff,  in_valid_in;
   req_payload_type in_item_ff,   in_item_in;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff,  out_data_in;
   logic            advance;
   logic            req_fire;
   logic [7:0]      motor_id;
   frame_type       frame;
   telem_view_type  view;

   // Configuration registers
   scrc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (csr_psel),
      .penable  (csr_penable),
      .pwrite   (csr_pwrite),
      .paddr    (csr_paddr),
      .pwdata   (csr_pwdata),
      .prdata   (csr_prdata),
      .pready   (csr_pready),
      .motor_id (motor_id)
   );

   // Advance the held request when the response register is free or drains
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign in_item_in   = req_fire ? req_chan.payload : in_item_ff;
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   // Build the frame for a command request
   scrc_frame_enc u_frame_enc (
      .item     (in_item_ff),
      .motor_id (motor_id),
      .frame    (frame)
   );

   // Decode a reply; telemetry commits only when the request moves forward
   scrc_telemetry #(
      .MOTOR_INDEX_LIMIT (MOTOR_INDEX_LIMIT)
   ) u_telemetry (
      .clock  (clock),
      .reset  (reset),
      .commit (advance),
      .item   (in_item_ff),
      .view   (view)
   );

   always_comb begin
      out_data_in = out_data_ff;
      if (advance) begin
         out_data_in.status         = view.status;
         out_data_in.tx_id          = frame.tx_id;
         out_data_in.tx_payload     = frame.tx_payload;
         out_data_in.temperature    = view.temperature;
         out_data_in.phase_current  = view.phase_current;
         out_data_in.speed_feedback = view.speed_feedback;
         out_data_in.shaft_angle    = view.shaft_angle;
         out_data_in.supply_voltage = view.supply_voltage;
         out_data_in.error_flags    = view.error_flags;
         out_data_in.relay_result   = view.relay_result;
         out_data_in.operating_mode = view.operating_mode;
         out_data_in.long_value     = view.long_value;
      end
   end

   // Control state clears on reset; payload registers just load
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

   // A held request that cannot move must still be held next cycle
   a_hold_request: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("held request dropped");

   // A response taken with nothing behind it leaves the output empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && !advance |=> !rsp_chan.valid)
      else $error("response repeated");

   // Only built frames carry an identifier or payload
   a_frame_only_built: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.payload.status != ST_BUILT) |->
      (rsp_chan.payload.tx_id == '0) && (rsp_chan.payload.tx_payload == '0))
      else $error("frame on a reply response");

   // A long value appears only for an accepted reply
   a_long_only_accepted: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.payload.long_value != '0) |->
      rsp_chan.payload.status == ST_ACCEPTED)
      else $error("long value without accepted reply");

endmodule
